>>> rtl/core/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
`default_nettype none

package qrs_pkg;

   localparam int CoeffWidthDef  = 16;
   localparam int ResultWidthDef = 32;
   // -b is scaled to units of 2^-15; the radicand carries 30 extra fraction bits.
   localparam int NegBShift      = 15;
   localparam int RadShift       = 30;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_TWO_REAL = 2'd0;
   localparam kind_type KIND_REPEATED = 2'd1;
   localparam kind_type KIND_COMPLEX  = 2'd2;
   localparam kind_type KIND_A_ZERO   = 2'd3;

   typedef struct packed {
      kind_type kind;
      logic     neg_first;
      logic     neg_second;
   } div_tag_type;

endpackage

`default_nettype wire

>>> rtl/core/quadratic_root_solver_unit.sv
// Top level of the quadratic root solver: pipeline, rounding and saturation.
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  tdata: coeff_a, coeff_b, coeff_c
//  rsp      out        rsp_tvalid/rsp_tready  tdata: first, second; tuser: kind, sat
//
// One item enters per cycle while rsp is not stalled; items pass the discriminant stages,
// the bit-per-stage square root, numerator preparation, the bit-per-stage divider and the output.
// Reset clears the valid bits of every stage and the output register.
// A stall on rsp freezes the whole pipeline; req_tready drops with it.
`default_nettype none

module quadratic_root_solver_unit #(
   parameter int COEFF_WIDTH  = qrs_pkg::CoeffWidthDef,
   parameter int RESULT_WIDTH = qrs_pkg::ResultWidthDef
) (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        req_tvalid,
   output logic                                       req_tready,
   // coeff_a, coeff_b, coeff_c, zero padding
   input  wire [((3*COEFF_WIDTH+7)/8)*8-1:0]          req_tdata,
   output logic                                       rsp_tvalid,
   input  wire                                        rsp_tready,
   // first_value, second_value, zero padding
   output logic [((2*RESULT_WIDTH+7)/8)*8-1:0]        rsp_tdata,
   // root_kind, saturated
   output logic [2:0]                                 rsp_tuser
);
   import qrs_pkg::*;

   localparam int CW    = COEFF_WIDTH;
   localparam int RW    = RESULT_WIDTH;
   localparam int MW    = 2*CW + 1;
   localparam int ROOTW = (MW + RadShift + 1) / 2;
   localparam int NBW   = CW + NegBShift + 2;
   localparam int NW    = ((NBW > ROOTW + 1) ? NBW : ROOTW + 1) + 1;
   localparam int SBW   = 2 + CW + NBW;
   localparam int CMPW  = ((NW > RW) ? NW : RW) + 1;
   localparam int OUTW  = ((2*RW+7)/8)*8;

   logic en;

   // discriminant stages
   logic                    disc_valid;
   kind_type                disc_kind;
   logic signed [CW-1:0]    disc_a;
   logic signed [NBW-1:0]   disc_nb;
   logic [MW-1:0]           disc_dmag;
   logic [2*ROOTW-1:0]      rad;

   // square root
   logic                    sq_valid;
   logic [ROOTW-1:0]        sq_root;
   logic [SBW-1:0]          sq_tag;
   kind_type                sq_kind;
   logic signed [CW-1:0]    sq_a;
   logic signed [NBW-1:0]   sq_nb;

   // numerator preparation
   logic signed [NW-1:0]    s_ext;
   logic signed [NW-1:0]    nb_ext;
   logic signed [NW-1:0]    n1;
   logic signed [NW-1:0]    n2;
   logic [NW-1:0]           nm1;
   logic [NW-1:0]           nm2;
   logic [CW-1:0]           den_in;
   div_tag_type             tag_in;
   logic                    prep_v_ff;
   logic [NW-1:0]           u1_ff;
   logic [NW-1:0]           u2_ff;
   logic [CW-1:0]           den_ff;
   div_tag_type             tag_ff;

   // divider and output
   logic                    dv_valid;
   logic [NW-1:0]           q1;
   logic [NW-1:0]           q2;
   div_tag_type             dv_tag;
   logic [RW:0]             sat1;
   logic [RW:0]             sat2;
   logic                    rsp_v_ff;
   kind_type                kind_ff;
   logic [RW-1:0]           first_ff;
   logic [RW-1:0]           second_ff;
   logic                    sat_ff;
   kind_type                kind_in;
   logic [RW-1:0]           first_in;
   logic [RW-1:0]           second_in;
   logic                    sat_in;

   // Sign and clip the rounded quotient to RESULT_WIDTH; bit RW is the clip flag.
   function automatic logic [RW:0] sat_result(input logic [NW-1:0] q, input logic neg);
      logic [CMPW-1:0] qe;
      logic [CMPW-1:0] pmax;
      logic            clip;
      logic            ng;
      qe   = CMPW'(q);
      pmax = (CMPW'(1) << (RW - 1)) - CMPW'(1);
      clip = 1'b0;
      ng   = neg && (q != '0);
      if (ng) begin
         if (qe > pmax + CMPW'(1)) begin
            qe   = pmax + CMPW'(1);
            clip = 1'b1;
         end
         qe = -qe;
      end else if (qe > pmax) begin
         qe   = pmax;
         clip = 1'b1;
      end
      return {clip, qe[RW-1:0]};
   endfunction

   assign en         = !rsp_v_ff || rsp_tready;
   assign req_tready = en;

   qrs_disc #(
      .COEFF_WIDTH(CW)
   ) u_disc (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .coeff_a  (req_tdata[CW-1:0]),
      .coeff_b  (req_tdata[2*CW-1:CW]),
      .coeff_c  (req_tdata[3*CW-1:2*CW]),
      .out_valid(disc_valid),
      .out_kind (disc_kind),
      .out_a    (disc_a),
      .out_nb   (disc_nb),
      .out_dmag (disc_dmag)
   );

   assign rad = (2*ROOTW)'(disc_dmag) << RadShift;

   qrs_sqrt #(
      .ROOT_WIDTH(ROOTW),
      .TAG_WIDTH (SBW)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (disc_valid),
      .in_rad   (rad),
      .in_tag   ({disc_kind, disc_a, disc_nb}),
      .out_valid(sq_valid),
      .out_root (sq_root),
      .out_tag  (sq_tag)
   );

   assign sq_nb   = sq_tag[NBW-1:0];
   assign sq_a    = sq_tag[NBW+CW-1:NBW];
   assign sq_kind = sq_tag[SBW-1:NBW+CW];

   assign s_ext  = $signed(NW'(sq_root));
   assign nb_ext = NW'(sq_nb);
   assign den_in = sq_a[CW-1] ? CW'(-sq_a) : CW'(sq_a);

   always_comb begin
      tag_in.kind = sq_kind;
      case (sq_kind)
         KIND_TWO_REAL: begin
            n1 = nb_ext + s_ext;
            n2 = nb_ext - s_ext;
            tag_in.neg_first  = n1[NW-1] ^ sq_a[CW-1];
            tag_in.neg_second = n2[NW-1] ^ sq_a[CW-1];
         end
         KIND_REPEATED: begin
            n1 = nb_ext;
            n2 = nb_ext;
            tag_in.neg_first  = n1[NW-1] ^ sq_a[CW-1];
            tag_in.neg_second = n1[NW-1] ^ sq_a[CW-1];
         end
         KIND_COMPLEX: begin
            // imaginary part over |a|: never negative
            n1 = nb_ext;
            n2 = s_ext;
            tag_in.neg_first  = n1[NW-1] ^ sq_a[CW-1];
            tag_in.neg_second = 1'b0;
         end
         default: begin
            n1 = '0;
            n2 = '0;
            tag_in.neg_first  = 1'b0;
            tag_in.neg_second = 1'b0;
         end
      endcase
   end

   assign nm1 = n1[NW-1] ? NW'(-n1) : NW'(n1);
   assign nm2 = n2[NW-1] ? NW'(-n2) : NW'(n2);

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_v_ff <= 1'b0;
      end else if (en) begin
         prep_v_ff <= sq_valid;
      end
   end

   // add half the divisor for rounding, ties away from zero
   always_ff @(posedge clock) begin
      if (en) begin
         u1_ff  <= nm1 + NW'(den_in >> 1);
         u2_ff  <= nm2 + NW'(den_in >> 1);
         den_ff <= den_in;
         tag_ff <= tag_in;
      end
   end

   qrs_div #(
      .NUM_WIDTH(NW),
      .DEN_WIDTH(CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (prep_v_ff),
      .in_num_a (u1_ff),
      .in_num_b (u2_ff),
      .in_den   (den_ff),
      .in_tag   (tag_ff),
      .out_valid(dv_valid),
      .out_quo_a(q1),
      .out_quo_b(q2),
      .out_tag  (dv_tag)
   );

   assign sat1 = sat_result(q1, dv_tag.neg_first);
   assign sat2 = sat_result(q2, dv_tag.neg_second);

   always_comb begin
      kind_in = dv_tag.kind;
      if (dv_tag.kind == KIND_A_ZERO) begin
         first_in  = '0;
         second_in = '0;
         sat_in    = 1'b0;
      end else begin
         first_in  = sat1[RW-1:0];
         second_in = sat2[RW-1:0];
         sat_in    = sat1[RW] | sat2[RW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         rsp_v_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff   <= kind_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = OUTW'({second_ff, first_ff});
   assign rsp_tuser  = {sat_ff, kind_ff};

endmodule

`default_nettype wire

>>> rtl/core/qrs_disc.sv
// Product and discriminant stages: classify the roots and form -b scaled.
`default_nettype none

module qrs_disc #(
   parameter int COEFF_WIDTH = 16
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    en,
   input  wire                                    in_valid,
   input  wire signed [COEFF_WIDTH-1:0]           coeff_a,
   input  wire signed [COEFF_WIDTH-1:0]           coeff_b,
   input  wire signed [COEFF_WIDTH-1:0]           coeff_c,
   output logic                                   out_valid,
   output qrs_pkg::kind_type                      out_kind,
   output logic signed [COEFF_WIDTH-1:0]          out_a,
   output logic signed [COEFF_WIDTH+qrs_pkg::NegBShift+1:0] out_nb,
   output logic [2*COEFF_WIDTH:0]                 out_dmag
);
   import qrs_pkg::*;

   localparam int CW  = COEFF_WIDTH;
   localparam int DW  = 2*CW + 3;
   localparam int MW  = 2*CW + 1;
   localparam int NBW = CW + NegBShift + 2;

   logic                   v1_ff;
   logic signed [CW-1:0]   a1_ff;
   logic signed [CW-1:0]   b1_ff;
   logic signed [2*CW-1:0] bb_ff;
   logic signed [2*CW-1:0] ac_ff;
   logic signed [2*CW-1:0] bb_in;
   logic signed [2*CW-1:0] ac_in;

   logic                   v2_ff;
   kind_type               kind_ff;
   kind_type               kind_in;
   logic signed [CW-1:0]   a2_ff;
   logic signed [NBW-1:0]  nb_ff;
   logic signed [NBW-1:0]  nb_in;
   logic [MW-1:0]          dmag_ff;
   logic [MW-1:0]          dmag_in;
   logic signed [DW-1:0]   d_in;
   logic signed [NBW-1:0]  b_ext;

   assign bb_in = (2*CW)'(coeff_b) * (2*CW)'(coeff_b);
   assign ac_in = (2*CW)'(coeff_a) * (2*CW)'(coeff_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff <= coeff_a;
         b1_ff <= coeff_b;
         bb_ff <= bb_in;
         ac_ff <= ac_in;
      end
   end

   assign d_in  = DW'(bb_ff) - (DW'(ac_ff) <<< 2);
   assign b_ext = NBW'(b1_ff);
   assign nb_in = -(b_ext <<< NegBShift);
   assign dmag_in = d_in[DW-1] ? MW'(-d_in) : MW'(d_in);

   always_comb begin
      if (a1_ff == '0) begin
         kind_in = KIND_A_ZERO;
      end else if (d_in == '0) begin
         kind_in = KIND_REPEATED;
      end else if (d_in[DW-1]) begin
         kind_in = KIND_COMPLEX;
      end else begin
         kind_in = KIND_TWO_REAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff <= kind_in;
         a2_ff   <= a1_ff;
         nb_ff   <= nb_in;
         dmag_ff <= dmag_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_kind  = kind_ff;
   assign out_a     = a2_ff;
   assign out_nb    = nb_ff;
   assign out_dmag  = dmag_ff;

endmodule

`default_nettype wire

>>> rtl/core/qrs_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a carried tag.
`default_nettype none

module qrs_sqrt #(
   parameter int ROOT_WIDTH = 32,
   parameter int TAG_WIDTH  = 8
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      en,
   input  wire                      in_valid,
   input  wire [2*ROOT_WIDTH-1:0]   in_rad,
   input  wire [TAG_WIDTH-1:0]      in_tag,
   output logic                     out_valid,
   output logic [ROOT_WIDTH-1:0]    out_root,
   output logic [TAG_WIDTH-1:0]     out_tag
);

   localparam int RW = ROOT_WIDTH;

   logic                  v_ff    [RW];
   logic [2*RW-1:0]       rad_ff  [RW];
   logic [RW+1:0]         rem_ff  [RW];
   logic [RW-1:0]         root_ff [RW];
   logic [TAG_WIDTH-1:0]  tag_ff  [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic                 v_p;
      logic [2*RW-1:0]      rad_p;
      logic [RW+1:0]        rem_p;
      logic [RW-1:0]        root_p;
      logic [TAG_WIDTH-1:0] tag_p;
      logic [RW+1:0]        cand;
      logic [RW+1:0]        sub;
      logic                 take;
      logic [RW+1:0]        rem_in;
      logic [RW-1:0]        root_in;

      if (k == 0) begin : g_first
         assign v_p    = in_valid;
         assign rad_p  = in_rad;
         assign rem_p  = '0;
         assign root_p = '0;
         assign tag_p  = in_tag;
      end else begin : g_next
         assign v_p    = v_ff[k-1];
         assign rad_p  = rad_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign tag_p  = tag_ff[k-1];
      end

      // Bring down two radicand bits and try root*4+1.
      assign cand    = {rem_p[RW-1:0], rad_p[2*RW-1:2*RW-2]};
      assign sub     = {root_p, 2'b01};
      assign take    = cand >= sub;
      assign rem_in  = take ? cand - sub : cand;
      assign root_in = {root_p[RW-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_p << 2;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            tag_ff[k]  <= tag_p;
         end
      end
   end

   assign out_valid = v_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_tag   = tag_ff[RW-1];

endmodule

`default_nettype wire

>>> rtl/core/qrs_div.sv
// Pipelined restoring divider, two numerators over one divisor, a bit per stage.
`default_nettype none

module qrs_div #(
   parameter int NUM_WIDTH = 34,
   parameter int DEN_WIDTH = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          en,
   input  wire                          in_valid,
   input  wire [NUM_WIDTH-1:0]          in_num_a,
   input  wire [NUM_WIDTH-1:0]          in_num_b,
   input  wire [DEN_WIDTH-1:0]          in_den,
   input  wire qrs_pkg::div_tag_type    in_tag,
   output logic                         out_valid,
   output logic [NUM_WIDTH-1:0]         out_quo_a,
   output logic [NUM_WIDTH-1:0]         out_quo_b,
   output qrs_pkg::div_tag_type         out_tag
);
   import qrs_pkg::*;

   localparam int NW = NUM_WIDTH;
   localparam int DV = DEN_WIDTH;

   logic          v_ff     [NW];
   logic [NW-1:0] num_a_ff [NW];
   logic [NW-1:0] num_b_ff [NW];
   logic [DV:0]   rem_a_ff [NW];
   logic [DV:0]   rem_b_ff [NW];
   logic [NW-1:0] quo_a_ff [NW];
   logic [NW-1:0] quo_b_ff [NW];
   logic [DV-1:0] den_ff   [NW];
   div_tag_type   tag_ff   [NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic          v_p;
      logic [NW-1:0] num_a_p;
      logic [NW-1:0] num_b_p;
      logic [DV:0]   rem_a_p;
      logic [DV:0]   rem_b_p;
      logic [NW-1:0] quo_a_p;
      logic [NW-1:0] quo_b_p;
      logic [DV-1:0] den_p;
      div_tag_type   tag_p;
      logic [DV:0]   cand_a;
      logic [DV:0]   cand_b;
      logic          take_a;
      logic          take_b;
      logic [DV:0]   rem_a_in;
      logic [DV:0]   rem_b_in;

      if (k == 0) begin : g_first
         assign v_p     = in_valid;
         assign num_a_p = in_num_a;
         assign num_b_p = in_num_b;
         assign rem_a_p = '0;
         assign rem_b_p = '0;
         assign quo_a_p = '0;
         assign quo_b_p = '0;
         assign den_p   = in_den;
         assign tag_p   = in_tag;
      end else begin : g_next
         assign v_p     = v_ff[k-1];
         assign num_a_p = num_a_ff[k-1];
         assign num_b_p = num_b_ff[k-1];
         assign rem_a_p = rem_a_ff[k-1];
         assign rem_b_p = rem_b_ff[k-1];
         assign quo_a_p = quo_a_ff[k-1];
         assign quo_b_p = quo_b_ff[k-1];
         assign den_p   = den_ff[k-1];
         assign tag_p   = tag_ff[k-1];
      end

      assign cand_a   = {rem_a_p[DV-1:0], num_a_p[NW-1]};
      assign cand_b   = {rem_b_p[DV-1:0], num_b_p[NW-1]};
      assign take_a   = cand_a >= {1'b0, den_p};
      assign take_b   = cand_b >= {1'b0, den_p};
      assign rem_a_in = take_a ? cand_a - {1'b0, den_p} : cand_a;
      assign rem_b_in = take_b ? cand_b - {1'b0, den_p} : cand_b;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_a_ff[k] <= num_a_p << 1;
            num_b_ff[k] <= num_b_p << 1;
            rem_a_ff[k] <= rem_a_in;
            rem_b_ff[k] <= rem_b_in;
            quo_a_ff[k] <= {quo_a_p[NW-2:0], take_a};
            quo_b_ff[k] <= {quo_b_p[NW-2:0], take_b};
            den_ff[k]   <= den_p;
            tag_ff[k]   <= tag_p;
         end
      end
   end

   assign out_valid = v_ff[NW-1];
   assign out_quo_a = quo_a_ff[NW-1];
   assign out_quo_b = quo_b_ff[NW-1];
   assign out_tag   = tag_ff[NW-1];

endmodule

`default_nettype wire

>>> bench/quadratic_root_solver_unit_checker.sv
// Checker for the quadratic root solver: root predictor and result comparison.
`timescale 1ns / 100ps
`default_nettype none

module quadratic_root_solver_unit_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [47:0] req_tdata,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [63:0] rsp_tdata,
   input  wire  [2:0]  rsp_tuser,
   output int          fail_count,
   output int          pending_roots,
   output int          roots_seen
);
   import qrs_pkg::*;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] first;
      logic [31:0] second;
      logic        sat;
   } roots_type;

   roots_type expected_roots[$];
   logic      clip;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Round to nearest, ties away from zero; clip to Q16.16 and flag it.
   function automatic logic [31:0] round_div(longint n, longint d);
      longint unsigned nm, dm, q;
      logic            neg;
      nm  = n < 0 ? -n : n;
      dm  = d < 0 ? -d : d;
      neg = (n < 0) != (d < 0);
      q   = (nm + dm / 2) / dm;
      if (q == 0) neg = 0;
      if (neg) begin
         if (q > 64'h8000_0000) begin
            q    = 64'h8000_0000;
            clip = 1;
         end
         return 32'(-q);
      end
      if (q > 64'h7fff_ffff) begin
         q    = 64'h7fff_ffff;
         clip = 1;
      end
      return 32'(q);
   endfunction

   function automatic roots_type solve_roots(logic [47:0] coeffs);
      longint    a, b, c, disc, nb;
      longint unsigned s;
      roots_type r;
      a    = longint'($signed(coeffs[15:0]));
      b    = longint'($signed(coeffs[31:16]));
      c    = longint'($signed(coeffs[47:32]));
      clip = 0;
      r    = '0;
      if (a == 0) begin
         r.kind = KIND_A_ZERO;
         return r;
      end
      disc = b * b - 4 * a * c;
      nb   = -b * 32768;
      if (disc > 0) begin
         s        = int_sqrt(longint'(disc) << 30);
         r.kind   = KIND_TWO_REAL;
         r.first  = round_div(nb + longint'(s), a);
         r.second = round_div(nb - longint'(s), a);
      end else if (disc == 0) begin
         r.kind   = KIND_REPEATED;
         r.first  = round_div(nb, a);
         r.second = r.first;
      end else begin
         s        = int_sqrt(longint'(-disc) << 30);
         r.kind   = KIND_COMPLEX;
         r.first  = round_div(nb, a);
         r.second = round_div(longint'(s), a < 0 ? -a : a);
      end
      r.sat = clip;
      return r;
   endfunction

   assign pending_roots = expected_roots.size();

   always @(posedge clock) begin
      roots_type e;
      if (reset) begin
         fail_count <= 0;
         roots_seen <= 0;
      end else begin
         if (req_tvalid && req_tready) expected_roots.push_back(solve_roots(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            roots_seen <= roots_seen + 1;
            if (expected_roots.size() == 0) begin
               $error("unexpected result item");
               fail_count <= fail_count + 1;
            end else begin
               e = expected_roots.pop_front();
               if (rsp_tuser[1:0] !== e.kind || rsp_tdata[31:0] !== e.first ||
                   rsp_tdata[63:32] !== e.second || rsp_tuser[2] !== e.sat)
                  fail_count <= fail_count + 1;
               if (rsp_tuser[1:0] !== e.kind)
                  $error("root_kind expected %0d got %0d", e.kind, rsp_tuser[1:0]);
               if (rsp_tdata[31:0] !== e.first)
                  $error("first_value expected %h got %h", e.first, rsp_tdata[31:0]);
               if (rsp_tdata[63:32] !== e.second)
                  $error("second_value expected %h got %h", e.second, rsp_tdata[63:32]);
               if (rsp_tuser[2] !== e.sat)
                  $error("saturated expected %b got %b", e.sat, rsp_tuser[2]);
            end
         end
      end
   end
endmodule

`default_nettype wire

>>> bench/quadratic_root_solver_unit_test.sv
// Testbench top for the quadratic root solver: stimulus, stalls and verdict.
`timescale 1ns / 100ps
`default_nettype none

module quadratic_root_solver_unit_test;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic [47:0] req_tdata = '0;
   logic        rsp_tready = 0;
   wire         req_tready, rsp_tvalid;
   wire  [63:0] rsp_tdata;
   wire  [2:0]  rsp_tuser;
   int          fail_count, pending_roots, roots_seen;
   logic        hold_off = 0;
   logic        drain_done = 0;

   always #5 clock = ~clock;

   quadratic_root_solver_unit u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   quadratic_root_solver_unit_checker u_check (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .fail_count, .pending_roots, .roots_seen
   );

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] pick_coeff();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(0, 64)) - 32);
         3: return 16'($urandom_range(0, 8) << 8);
         default: return 16'($urandom);
      endcase
   endfunction

   // Hold tvalid across back-to-back items; drop it only for a gap.
   task automatic send_coeffs(logic [15:0] a, logic [15:0] b, logic [15:0] c, int gap);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {c, b, a};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      do @(posedge clock); while (pending_roots != 0);
   endtask

   // Receiver: random stalls, plus one long hold-off while the sender keeps going.
   initial begin
      int   g;
      logic held;
      held = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off && !held) begin
            held = 1;
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
         end
         g = drain_done ? 0 : gap_len();
         if (g > 0 && $urandom_range(0, 1)) begin
            rsp_tready <= 0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1;
      end
   end

   initial begin
      int n, wait_cycles;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Zero a, repeated, complex, saturating and extreme codes.
      send_coeffs(16'h0000, 16'h1234, 16'h5678, 0);
      send_coeffs(16'h0000, 16'h0000, 16'h0000, 0);
      send_coeffs(16'h0100, 16'h0200, 16'h0100, 0);
      send_coeffs(16'h0100, 16'h0000, 16'h0100, 0);
      send_coeffs(16'h0100, 16'hfd00, 16'h0200, 0);
      send_coeffs(16'h0001, 16'h7fff, 16'h0000, 0);
      send_coeffs(16'h0001, 16'h8000, 16'h8000, 0);
      send_coeffs(16'hffff, 16'h8000, 16'h7fff, 0);
      send_coeffs(16'h8000, 16'h8000, 16'h8000, 0);
      send_coeffs(16'h7fff, 16'h7fff, 16'h7fff, 0);
      send_coeffs(16'h8000, 16'h0000, 16'h7fff, 0);
      send_coeffs(16'hffff, 16'hffff, 16'hffff, 0);
      send_coeffs(16'h0001, 16'h0001, 16'h0001, 0);
      send_coeffs(16'hff00, 16'h0000, 16'h0000, 0);
      send_coeffs(16'h0300, 16'h0600, 16'h0300, 0);
      send_coeffs(16'h5555, 16'haaaa, 16'h5555, 0);
      // Pause until every expected result has come.
      wait_drained();
      hold_off <= 1;
      for (n = 0; n < 1950; n++) begin
         if (n == 1000) wait_drained();
         if ($urandom_range(0, 3) == 0)
            send_coeffs(16'($urandom), 16'($urandom), 16'($urandom), gap_len());
         else if ($urandom_range(0, 4) == 0) begin
            // Repeated root: b = 2k, a = 1.0, c = k*k.
            logic [15:0] k;
            k = 16'($signed($urandom_range(0, 22)) - 11);
            send_coeffs(16'h0100, 16'(2 * $signed(k)) << 8, 16'($signed(k) * $signed(k)) << 8,
                        gap_len());
         end else
            send_coeffs(pick_coeff(), pick_coeff(), pick_coeff(), gap_len());
      end
      req_tvalid <= 0;
      drain_done <= 1;
      wait_cycles = 0;
      while (pending_roots != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      $display("Checked %0d coefficient sets: zero a, repeated, complex, real and clipped roots,",
               roots_seen);
      $display("with random source gaps, sink stalls and one long sink hold-off.");
      if (fail_count == 0 && pending_roots == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule

`default_nettype wire
